### hw/rtl/mps_pkg.sv
// ----------------------------------------------------------------------------
// Masked pattern search package
// Shared sizes, codes and item types of the masked byte-pattern search.
// ----------------------------------------------------------------------------
package mps_pkg;

  // Number of pattern positions, and so of cells in the chain.
  localparam int MaxPattern = 256;
  localparam int SelW       = (MaxPattern > 1) ? $clog2(MaxPattern) : 1;

  localparam int LenW       = 9;
  localparam int LimitW     = 16;
  localparam int AddrW      = 32;
  localparam int SeenW      = 33;
  localparam int CfgIdxW    = 2;
  localparam int CfgDataW   = 32;

  localparam logic [LimitW-1:0] ResetLimit = 16'd1024;
  localparam logic [SeenW-1:0]  SeenMax    = {SeenW{1'b1}};

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_SCAN = 1'b1
  } op_e;

  typedef enum logic {
    KIND_HIT     = 1'b0,
    KIND_SUMMARY = 1'b1
  } kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_PATTERN_LENGTH = 2'd0,
    REG_HIT_LIMIT      = 2'd1,
    REG_START_ADDRESS  = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] pattern_index;
    logic [7:0] pattern_byte;
    logic [7:0] mask_byte;
    logic [7:0] data_byte;
    logic       final_byte;
  } in_item_t;

  typedef struct packed {
    kind_e              result_kind;
    logic [AddrW-1:0]   hit_address;
    logic [LimitW-1:0]  hit_count;
    logic               truncated;
    logic [SeenW-1:0]   scanned_count;
    logic               run_end;
  } out_item_t;

  // Control of the cell chain for one cycle.
  typedef struct packed {
    logic       step;
    logic       replay;
    logic [7:0] data;
    logic       load;
    logic [7:0] load_idx;
    logic [7:0] load_pat;
    logic [7:0] load_mask;
  } chain_ctrl_t;

  // One or two results handed to the output buffer at once.
  typedef struct packed {
    logic      valid;
    logic      two;
    out_item_t first;
    out_item_t second;
  } res_push_t;

endpackage

### hw/rtl/mps_if.sv
// ----------------------------------------------------------------------------
// Masked pattern search channels
// Valid/ready channels carrying input items and result items.
// ----------------------------------------------------------------------------
interface mps_in_if;
  logic               valid;
  logic               ready;
  mps_pkg::in_item_t  item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

interface mps_out_if;
  logic               valid;
  logic               ready;
  mps_pkg::out_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

### hw/rtl/mps_cell.sv
// ----------------------------------------------------------------------------
// Masked pattern search cell
// Holds one pattern position and one window byte, and carries the prefix
// match flag of the alignment that reaches this position.
// ----------------------------------------------------------------------------
module mps_cell (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic       load_i,
  input  logic [7:0] load_pat_i,
  input  logic [7:0] load_mask_i,
  input  logic [7:0] byte_i,
  input  logic [7:0] bcast_i,
  input  logic       flag_i,
  output logic [7:0] byte_o,
  output logic       flag_o
);

  logic [7:0] pat_q;
  logic [7:0] mask_q;
  logic [7:0] win_q;
  logic       flag_q;
  logic       eq;

  assign eq = (bcast_i & mask_q) == pat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= 8'hff;
      flag_q <= 1'b0;
    end else begin
      if (load_i) begin
        mask_q <= load_mask_i;
      end
      if (step_i) begin
        flag_q <= flag_i & eq;
      end
    end
  end

  // The pattern is kept pre-masked.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      pat_q <= load_pat_i & load_mask_i;
    end
    if (step_i) begin
      win_q <= byte_i;
    end
  end

  assign byte_o = win_q;
  assign flag_o = flag_q;

endmodule

### hw/rtl/mps_chain.sv
// ----------------------------------------------------------------------------
// Masked pattern search cell chain
// A row of cells: the newest byte is compared in every cell at once and the
// prefix flags move one cell on per byte, so the flag of the cell at the
// last pattern position tells whether the latest alignment matches.
// ----------------------------------------------------------------------------
module mps_chain (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  mps_pkg::chain_ctrl_t      ctrl_i,
  input  logic [mps_pkg::SelW-1:0]  sel_i,
  output logic                      match_o
);

  logic [7:0] win   [mps_pkg::MaxPattern];
  logic [7:0] win_in[mps_pkg::MaxPattern];
  logic       flag  [mps_pkg::MaxPattern];
  logic       flag_in[mps_pkg::MaxPattern];
  logic [7:0] head_byte;

  // During a replay the window rotates, so the oldest byte re-enters the row.
  assign head_byte = ctrl_i.replay ? win[mps_pkg::MaxPattern-1] : ctrl_i.data;

  for (genvar g = 0; g < mps_pkg::MaxPattern; g++) begin : g_cells
    if (g == 0) begin : g_head
      assign win_in[g]  = head_byte;
      assign flag_in[g] = 1'b1;
    end else begin : g_body
      assign win_in[g]  = win[g-1];
      assign flag_in[g] = flag[g-1];
    end

    mps_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .step_i      (ctrl_i.step),
      .load_i      (ctrl_i.load && (int'(ctrl_i.load_idx) == g)),
      .load_pat_i  (ctrl_i.load_pat),
      .load_mask_i (ctrl_i.load_mask),
      .byte_i      (win_in[g]),
      .bcast_i     (head_byte),
      .flag_i      (flag_in[g]),
      .byte_o      (win[g]),
      .flag_o      (flag[g])
    );
  end

  assign match_o = flag[sel_i];

endmodule

### hw/rtl/mps_result_buf.sv
// ----------------------------------------------------------------------------
// Masked pattern search result buffer
// Two-entry output register that holds the results of one item while the
// receiver stalls.
// ----------------------------------------------------------------------------
module mps_result_buf (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mps_pkg::res_push_t   push_i,
  output logic                 empty_o,
  mps_out_if.source            out_o
);

  mps_pkg::out_item_t entry_q [2];
  logic               rd_q, rd_d;
  logic [1:0]         cnt_q, cnt_d;
  logic               pop;

  assign out_o.valid = cnt_q != 2'd0;
  assign out_o.item  = entry_q[rd_q];
  assign empty_o     = cnt_q == 2'd0;
  assign pop         = out_o.valid && out_o.ready;

  always_comb begin
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i.valid) begin
      rd_d  = 1'b0;
      cnt_d = push_i.two ? 2'd2 : 2'd1;
    end else if (pop) begin
      rd_d  = rd_q + 1'b1;
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      entry_q[0] <= push_i.first;
      entry_q[1] <= push_i.second;
    end
  end

  a_push_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.valid |-> cnt_q == 2'd0)
    else $error("result pushed into a non-empty buffer");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("result buffer count out of range");

  a_push_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.valid |=> out_o.valid && rd_q == 1'b0)
    else $error("pushed result not presented from the first entry");

endmodule

### hw/rtl/masked_pattern_search_core.sv
// ----------------------------------------------------------------------------
// Masked pattern search core
// Streams memory bytes past a masked pattern held in a chain of cells and
// reports each match address up to the hit limit and a summary when a scan ends.
//
// Usage: in_i carries load items (one pattern byte and mask each) and scan
// items (one memory byte each, the last flagged by final_byte). out_o carries
// hit items and end-of-scan summaries; run_end marks the last result of an
// item. Registers are written through cfg_we_i / cfg_idx_i / cfg_data_i; the
// user must write them only while the block is idle; it does not enforce this.
// A scan item is accepted in ST_IDLE and then evaluated in ST_EVAL, and no new
// item is taken until that evaluation is done; the compare itself is done by
// all cells at once. Its results appear on out_o the cycle after evaluation.
// A load item writes one cell, and a replay follows when it lands in the middle
// of a scan: the cell window rotates once to rebuild the match flags against
// the new pattern.
// A two-entry output buffer holds the results, so the next item is accepted
// while the receiver stalls; evaluation waits until the buffer is empty.
// Reset sets the registers to their defaults, all masks to ones and clears
// the scan state; no clearing pass is needed.
// ----------------------------------------------------------------------------
module masked_pattern_search_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [mps_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [mps_pkg::CfgDataW-1:0]  cfg_data_i,
  mps_in_if.sink                        in_i,
  mps_out_if.source                     out_o
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_EVAL   = 3'b010,
    ST_REPLAY = 3'b100
  } state_e;

  state_e                          state_q, state_d;
  logic [mps_pkg::SelW-1:0]        len_sel_q, len_sel_d;
  logic [mps_pkg::LimitW-1:0]      limit_q, limit_d;
  logic [mps_pkg::AddrW-1:0]       start_q, start_d;
  logic [mps_pkg::SeenW-1:0]       bytes_q, bytes_d;
  logic [mps_pkg::LimitW-1:0]      hits_q, hits_d;
  logic                            stopped_q, stopped_d;
  logic                            final_q, final_d;
  logic [mps_pkg::SelW-1:0]        replay_cnt_q, replay_cnt_d;

  logic [mps_pkg::LenW-1:0]        len_v;
  logic                            in_fire;
  logic                            is_scan;
  logic                            match;
  logic                            buf_empty;
  logic                            aligned;
  logic [mps_pkg::SeenW-1:0]       scanned;
  logic [mps_pkg::AddrW-1:0]       hit_addr;
  logic [mps_pkg::LimitW-1:0]      hits_inc;
  logic                            hit;
  logic                            limit_hit;
  mps_pkg::out_item_t              hit_item;
  mps_pkg::out_item_t              sum_item;
  mps_pkg::res_push_t              push;
  mps_pkg::chain_ctrl_t            ctrl;

  assign in_i.ready = state_q == ST_IDLE;
  assign in_fire    = in_i.valid && in_i.ready;
  assign is_scan    = in_i.item.op == mps_pkg::OP_SCAN;

  // ---- configuration registers ----
  assign len_v = cfg_data_i[mps_pkg::LenW-1:0];

  always_comb begin
    len_sel_d = len_sel_q;
    limit_d   = limit_q;
    start_d   = start_q;
    if (cfg_we_i) begin
      case (mps_pkg::cfg_reg_e'(cfg_idx_i))
        mps_pkg::REG_PATTERN_LENGTH: begin
          if (len_v == '0) begin
            len_sel_d = '0;
          end else if (int'(len_v) > mps_pkg::MaxPattern) begin
            len_sel_d = mps_pkg::SelW'(mps_pkg::MaxPattern - 1);
          end else begin
            len_sel_d = mps_pkg::SelW'(len_v - 9'd1);
          end
        end
        mps_pkg::REG_HIT_LIMIT: begin
          limit_d = (cfg_data_i[mps_pkg::LimitW-1:0] == '0) ?
                    16'd1 : cfg_data_i[mps_pkg::LimitW-1:0];
        end
        mps_pkg::REG_START_ADDRESS: begin
          start_d = cfg_data_i[mps_pkg::AddrW-1:0];
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_sel_q <= '0;
      limit_q   <= mps_pkg::ResetLimit;
      start_q   <= '0;
    end else begin
      len_sel_q <= len_sel_d;
      limit_q   <= limit_d;
      start_q   <= start_d;
    end
  end

  // ---- cell chain ----
  always_comb begin
    ctrl.step      = (in_fire && is_scan && !stopped_q) || state_q == ST_REPLAY;
    ctrl.replay    = state_q == ST_REPLAY;
    ctrl.data      = in_i.item.data_byte;
    ctrl.load      = in_fire && !is_scan &&
                     (int'(in_i.item.pattern_index) < mps_pkg::MaxPattern);
    ctrl.load_idx  = in_i.item.pattern_index;
    ctrl.load_pat  = in_i.item.pattern_byte;
    ctrl.load_mask = in_i.item.mask_byte;
  end

  mps_chain u_chain (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .sel_i   (len_sel_q),
    .match_o (match)
  );

  // ---- evaluation of the latest alignment ----
  // The alignment is complete once more bytes than the last pattern index
  // have arrived; its start is bytes - length, i.e. bytes + ~sel.
  assign aligned   = bytes_q > mps_pkg::SeenW'(len_sel_q);
  assign scanned   = aligned ? bytes_q - mps_pkg::SeenW'(len_sel_q) : '0;
  assign hit_addr  = start_q + bytes_q[mps_pkg::AddrW-1:0] +
                     ~mps_pkg::AddrW'(len_sel_q);
  assign hits_inc  = hits_q + 16'd1;
  assign hit       = aligned && match;
  assign limit_hit = hit && (hits_inc >= limit_q);

  always_comb begin
    hit_item.result_kind   = mps_pkg::KIND_HIT;
    hit_item.hit_address   = hit_addr;
    hit_item.hit_count     = hits_inc;
    hit_item.truncated     = 1'b0;
    hit_item.scanned_count = '0;
    hit_item.run_end       = !(limit_hit || final_q);

    sum_item.result_kind   = mps_pkg::KIND_SUMMARY;
    sum_item.hit_address   = '0;
    sum_item.hit_count     = hit ? hits_inc : hits_q;
    sum_item.truncated     = limit_hit;
    sum_item.scanned_count = scanned;
    sum_item.run_end       = 1'b1;
  end

  // ---- sequencing ----
  always_comb begin
    state_d      = state_q;
    bytes_d      = bytes_q;
    hits_d       = hits_q;
    stopped_d    = stopped_q;
    final_d      = final_q;
    replay_cnt_d = replay_cnt_q;
    push         = '0;

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (!is_scan) begin
            // A new pattern byte in the middle of a scan invalidates the flags.
            if (bytes_q != '0 && !stopped_q) begin
              state_d      = ST_REPLAY;
              replay_cnt_d = mps_pkg::SelW'(mps_pkg::MaxPattern - 1);
            end
          end else if (stopped_q) begin
            if (in_i.item.final_byte) begin
              bytes_d   = '0;
              hits_d    = '0;
              stopped_d = 1'b0;
            end
          end else begin
            if (bytes_q != mps_pkg::SeenMax) begin
              bytes_d = bytes_q + 33'd1;
            end
            final_d = in_i.item.final_byte;
            state_d = ST_EVAL;
          end
        end
      end

      ST_REPLAY: begin
        if (replay_cnt_q == '0) begin
          state_d = ST_IDLE;
        end else begin
          replay_cnt_d = replay_cnt_q - mps_pkg::SelW'(1);
        end
      end

      ST_EVAL: begin
        if (buf_empty) begin
          state_d = ST_IDLE;
          if (hit) begin
            hits_d      = hits_inc;
            push.valid  = 1'b1;
            push.first  = hit_item;
            push.second = sum_item;
            push.two    = limit_hit || final_q;
            if (limit_hit) begin
              stopped_d = 1'b1;
            end
          end else if (final_q) begin
            push.valid = 1'b1;
            push.first = sum_item;
          end
          if (final_q) begin
            bytes_d   = '0;
            hits_d    = '0;
            stopped_d = 1'b0;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      bytes_q      <= '0;
      hits_q       <= '0;
      stopped_q    <= 1'b0;
      final_q      <= 1'b0;
      replay_cnt_q <= '0;
    end else begin
      state_q      <= state_d;
      bytes_q      <= bytes_d;
      hits_q       <= hits_d;
      stopped_q    <= stopped_d;
      final_q      <= final_d;
      replay_cnt_q <= replay_cnt_d;
    end
  end

  mps_result_buf u_result_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .empty_o (buf_empty),
    .out_o   (out_o)
  );

  a_eval_not_stopped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EVAL |-> !stopped_q)
    else $error("evaluation entered while the scan is stopped");

  a_hits_need_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bytes_q == '0 |-> hits_q == '0)
    else $error("hits counted without any scanned byte");

  a_replay_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_REPLAY && replay_cnt_q != '0) |=> state_q == ST_REPLAY)
    else $error("replay ended early");

  a_scan_evaluates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && is_scan && !stopped_q) |=> state_q == ST_EVAL)
    else $error("accepted scan item was not evaluated");

endmodule

### tb/masked_pattern_search_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Masked pattern search checker
// Watches the configuration port and both channels of the search core, keeps
// its own copy of the pattern store, byte window and scan counters, and
// compares every result item with the oldest one predicted.
// ----------------------------------------------------------------------------
module masked_pattern_search_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [mps_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [mps_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  mps_pkg::in_item_t             in_item_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  mps_pkg::out_item_t            out_item_i,
  output int                            fail_count_o,
  output int                            pending_o,
  output int                            hits_seen_o,
  output int                            summaries_seen_o,
  output int                            truncations_seen_o
);
  import mps_pkg::*;

  localparam int PrintLimit = 20;

  logic [LenW-1:0]   len_reg;
  logic [LimitW-1:0] limit_reg;
  logic [AddrW-1:0]  base_reg;

  logic [7:0]        want_byte [MaxPattern];
  logic [7:0]        care_mask [MaxPattern];
  logic [7:0]        window    [MaxPattern];
  logic [SeenW-1:0]  bytes_in;
  logic [LimitW-1:0] hit_tally;
  logic              halted;

  out_item_t         due_results [$];
  int                results_checked;

  function automatic void clear_scan();
    for (int i = 0; i < MaxPattern; i++) window[i] = 8'h00;
    bytes_in  = '0;
    hit_tally = '0;
    halted    = 1'b0;
  endfunction

  function automatic void reset_model();
    len_reg   = LenW'(1);
    limit_reg = ResetLimit;
    base_reg  = '0;
    for (int i = 0; i < MaxPattern; i++) begin
      care_mask[i] = 8'hFF;
      want_byte[i] = 8'h00;
    end
    clear_scan();
    due_results.delete();
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    fail_count_o++;
    if (fail_count_o <= PrintLimit)
      $display("[%0t] result %0d: %s is %0h, should be %0h", $realtime, results_checked,
               what, got, want);
  endtask

  task automatic check_result(out_item_t got);
    out_item_t want;
    if (due_results.size() == 0) begin
      report_mismatch("result with none due, kind", got.result_kind, 0);
    end else begin
      want = due_results.pop_front();
      if (got.result_kind !== want.result_kind)
        report_mismatch("result_kind", got.result_kind, want.result_kind);
      if (got.hit_address !== want.hit_address)
        report_mismatch("hit_address", got.hit_address, want.hit_address);
      if (got.hit_count !== want.hit_count)
        report_mismatch("hit_count", got.hit_count, want.hit_count);
      if (got.truncated !== want.truncated)
        report_mismatch("truncated", got.truncated, want.truncated);
      if (got.scanned_count !== want.scanned_count)
        report_mismatch("scanned_count", got.scanned_count, want.scanned_count);
      if (got.run_end !== want.run_end)
        report_mismatch("run_end", got.run_end, want.run_end);
    end
    if (got.result_kind == KIND_HIT) hits_seen_o++;
    else summaries_seen_o++;
    if (got.truncated === 1'b1) truncations_seen_o++;
    results_checked++;
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    case (idx)
      REG_PATTERN_LENGTH: len_reg   = data[LenW-1:0];
      REG_HIT_LIMIT:      limit_reg = data[LimitW-1:0];
      REG_START_ADDRESS:  base_reg  = data[AddrW-1:0];
      default: ;
    endcase
  endtask

  // Works out the results that one accepted item causes and queues them.
  task automatic predict_search(in_item_t it);
    int unsigned      n;
    int unsigned      lim;
    logic [SeenW-1:0] align;
    logic             match;
    out_item_t        res [2];
    int               cnt;
    bit               done;
    cnt  = 0;
    done = 1'b0;
    if (it.op == OP_LOAD) begin
      care_mask[it.pattern_index] = it.mask_byte;
      want_byte[it.pattern_index] = it.pattern_byte & it.mask_byte;
    end else if (halted) begin
      // After truncation bytes are dropped; only the final one clears the scan.
      if (it.final_byte) clear_scan();
    end else begin
      n   = (len_reg == 0) ? 1 : ((len_reg > MaxPattern) ? MaxPattern : len_reg);
      lim = (limit_reg == 0) ? 1 : limit_reg;
      for (int i = MaxPattern - 1; i > 0; i--) window[i] = window[i-1];
      window[0] = it.data_byte;
      if (bytes_in != SeenMax) bytes_in = bytes_in + SeenW'(1);
      if (bytes_in >= SeenW'(n)) begin
        match = 1'b1;
        for (int i = 0; i < n; i++)
          if ((window[n-1-i] & care_mask[i]) != want_byte[i]) match = 1'b0;
        if (match) begin
          align     = bytes_in - SeenW'(n);
          hit_tally = hit_tally + LimitW'(1);
          res[cnt]             = '0;
          res[cnt].result_kind = KIND_HIT;
          res[cnt].hit_address = base_reg + align[AddrW-1:0];
          res[cnt].hit_count   = hit_tally;
          cnt++;
          if (hit_tally >= lim) begin
            res[cnt]               = '0;
            res[cnt].result_kind   = KIND_SUMMARY;
            res[cnt].hit_count     = hit_tally;
            res[cnt].truncated     = 1'b1;
            res[cnt].scanned_count = align + SeenW'(1);
            cnt++;
            halted = 1'b1;
            done   = 1'b1;
            if (it.final_byte) clear_scan();
          end
        end
      end
      if (it.final_byte && !done) begin
        res[cnt]               = '0;
        res[cnt].result_kind   = KIND_SUMMARY;
        res[cnt].hit_count     = hit_tally;
        res[cnt].scanned_count = (bytes_in >= SeenW'(n)) ?
                                 bytes_in - SeenW'(n) + SeenW'(1) : '0;
        cnt++;
        clear_scan();
      end
    end
    if (cnt > 0) res[cnt-1].run_end = 1'b1;
    for (int k = 0; k < cnt; k++) due_results = {due_results, res[k]};
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reset_model();
    end else begin
      if (out_valid_i && out_ready_i) check_result(out_item_i);
      if (cfg_we_i) write_reg(cfg_idx_i, cfg_data_i);
      if (in_valid_i && in_ready_i) predict_search(in_item_i);
    end
    pending_o = due_results.size();
  end

endmodule

### tb/masked_pattern_search_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Masked pattern search core testbench
// Loads masked patterns and streams memory bytes into the core, first in a
// short directed sequence, then in random phases with planted matches, under
// changing sender gaps and receiver stalls. A checker beside the core predicts
// and compares every result item.
// ----------------------------------------------------------------------------
module masked_pattern_search_core_test;
  import mps_pkg::*;

  localparam int TailCycles  = MaxPattern + 16;
  localparam int CycleLimit  = 2_000_000;
  localparam int RandomItems = 1200;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_data;

  mps_in_if  in_ch ();
  mps_out_if out_ch ();

  int chk_failures;
  int chk_pending;
  int chk_hits;
  int chk_summaries;
  int chk_truncations;

  int unsigned idle_pct;
  int unsigned stall_pct;
  int          cycle_count;
  int          load_count;
  int          scan_count;
  int          phase;
  int unsigned act_len;
  logic [7:0]  pat_val [MaxPattern];
  logic [7:0]  pat_msk [MaxPattern];

  masked_pattern_search_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  masked_pattern_search_checker checker_inst (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we),
    .cfg_idx_i          (cfg_idx),
    .cfg_data_i         (cfg_data),
    .in_valid_i         (in_ch.valid),
    .in_ready_i         (in_ch.ready),
    .in_item_i          (in_ch.item),
    .out_valid_i        (out_ch.valid),
    .out_ready_i        (out_ch.ready),
    .out_item_i         (out_ch.item),
    .fail_count_o       (chk_failures),
    .pending_o          (chk_pending),
    .hits_seen_o        (chk_hits),
    .summaries_seen_o   (chk_summaries),
    .truncations_seen_o (chk_truncations)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("Timed out after %0d cycles with %0d results due", cycle_count, chk_pending);
      $display("FAILURE");
      $finish;
    end
  end

  always @(negedge clk_i) out_ch.ready <= ($urandom_range(99) >= stall_pct);

  // Offers one item, idling first at random, and returns at the accepting edge.
  task automatic push_item(in_item_t it);
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.item  <= it;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    if (it.op == OP_LOAD) load_count++;
    else scan_count++;
  endtask

  // Stops sending until every due result is in, optionally waiting out a replay.
  task automatic settle(bit with_tail);
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (chk_pending != 0) @(negedge clk_i);
    if (with_tail) repeat (TailCycles) @(negedge clk_i);
  endtask

  task automatic set_reg(cfg_reg_e idx, logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(negedge clk_i);
    cfg_we   <= 1'b0;
  endtask

  task automatic set_length(int unsigned len);
    set_reg(REG_PATTERN_LENGTH, len);
    act_len = (len == 0) ? 1 : ((len > MaxPattern) ? MaxPattern : len);
  endtask

  task automatic load_entry(int unsigned idx, logic [7:0] pat, logic [7:0] msk);
    in_item_t it;
    it.op            = OP_LOAD;
    it.pattern_index = idx[7:0];
    it.pattern_byte  = pat;
    it.mask_byte     = msk;
    it.data_byte     = 8'($urandom);
    it.final_byte    = 1'($urandom);
    pat_val[idx]     = pat;
    pat_msk[idx]     = msk;
    push_item(it);
  endtask

  task automatic scan_byte(logic [7:0] d, bit fin);
    in_item_t it;
    it.op            = OP_SCAN;
    it.pattern_index = 8'($urandom);
    it.pattern_byte  = 8'($urandom);
    it.mask_byte     = 8'($urandom);
    it.data_byte     = d;
    it.final_byte    = fin;
    push_item(it);
  endtask

  function automatic logic [7:0] pick_mask();
    int unsigned r;
    r = $urandom_range(9);
    if (r < 5) return 8'hFF;
    if (r < 7) return 8'($urandom);
    if (r < 8) return 8'h00;
    return 8'($urandom) & 8'($urandom);
  endfunction

  // A byte that satisfies pattern position pos, with the don't-care bits random.
  function automatic logic [7:0] planted(int unsigned pos);
    return (pat_val[pos] & pat_msk[pos]) | (8'($urandom) & ~pat_msk[pos]);
  endfunction

  task automatic load_pattern(int unsigned len);
    for (int unsigned i = 0; i < len; i++) load_entry(i, 8'($urandom), pick_mask());
  endtask

  // One scan from first to final byte: planted matches, near misses and noise,
  // with an occasional pattern reload in the middle.
  task automatic scan_run(int unsigned nbytes, bit lead_plant, int unsigned reload_pct,
                          bit hold_mid);
    int          pos;
    int unsigned r;
    int unsigned idx;
    logic [7:0]  d;
    pos = lead_plant ? 0 : -1;
    for (int unsigned b = 0; b < nbytes; b++) begin
      r = $urandom_range(99);
      if (pos < 0 && r < 30) pos = 0;
      if (pos >= 0) begin
        d = planted(pos);
        pos++;
        if (pos >= act_len) pos = -1;
      end else if (r < 60) begin
        d = planted($urandom_range(act_len - 1));
      end else begin
        d = 8'($urandom);
      end
      scan_byte(d, b == nbytes - 1);
      if (b + 1 < nbytes) begin
        if (hold_mid && b == nbytes / 2) settle(1'b0);
        if ($urandom_range(99) < reload_pct) begin
          idx = $urandom_range(1) ? $urandom_range(act_len - 1) : $urandom_range(MaxPattern - 1);
          load_entry(idx, 8'($urandom), pick_mask());
        end
      end
    end
  endtask

  task automatic directed_part();
    load_entry(MaxPattern - 1, 8'hFF, 8'h00);
    load_entry(0, 8'hA5, 8'hFF);
    // Reset settings: single-byte pattern, default limit, start address zero.
    scan_byte(8'hA5, 1'b0);
    scan_byte(8'h00, 1'b0);
    scan_byte(8'hFF, 1'b0);
    scan_byte(8'hA5, 1'b1);
    scan_byte(8'h5A, 1'b1);
    // Zero length acts as one; hits wrap past the top of the address space
    // until the limit stops the scan, and later bytes are ignored.
    settle(1'b1);
    set_length(0);
    set_reg(REG_HIT_LIMIT, 3);
    set_reg(REG_START_ADDRESS, 32'hFFFF_FFFE);
    scan_byte(8'hA5, 1'b0);
    scan_byte(8'hA5, 1'b0);
    scan_byte(8'hA5, 1'b0);
    scan_byte(8'hA5, 1'b0);
    scan_byte(8'h00, 1'b1);
    // A zero limit acts as one, reached here on the final byte.
    settle(1'b1);
    set_reg(REG_HIT_LIMIT, 0);
    scan_byte(8'h00, 1'b0);
    scan_byte(8'hA5, 1'b1);
    // Two-byte pattern with a partial mask: short run, overlapping matches,
    // and a reload in the middle of a scan.
    settle(1'b1);
    set_length(2);
    set_reg(REG_HIT_LIMIT, 16'hFFFF);
    set_reg(REG_START_ADDRESS, 32'h0000_1000);
    load_entry(0, 8'h3C, 8'hF0);
    load_entry(1, 8'h3C, 8'hFF);
    scan_byte(8'h3C, 1'b1);
    scan_byte(8'h31, 1'b0);
    scan_byte(8'h3C, 1'b0);
    scan_byte(8'h3C, 1'b1);
    scan_byte(8'h3C, 1'b0);
    scan_byte(8'h3C, 1'b0);
    load_entry(1, 8'h00, 8'h00);
    scan_byte(8'h77, 1'b1);
  endtask

  task automatic long_pattern_phase();
    settle(1'b1);
    set_length(MaxPattern);
    set_reg(REG_HIT_LIMIT, ResetLimit);
    set_reg(REG_START_ADDRESS, $urandom);
    load_pattern(MaxPattern);
    scan_run(MaxPattern + 6, 1'b1, 0, 1'b0);
    // Lengths beyond the store act as the full store.
    settle(1'b1);
    set_length((1 << LenW) - 1);
    scan_run(MaxPattern + 3, 1'b1, 1, 1'b0);
  endtask

  task automatic random_phase();
    int unsigned r;
    int unsigned runs;
    r = $urandom_range(15);
    settle(1'b1);
    if (r == 0) set_length(0);
    else if (r == 1) set_length($urandom_range(24, 9));
    else set_length($urandom_range(6, 1));
    r = $urandom_range(9);
    if (r == 0) set_reg(REG_HIT_LIMIT, 0);
    else if (r == 1) set_reg(REG_HIT_LIMIT, 16'hFFFF);
    else if (r == 2) set_reg(REG_HIT_LIMIT, ResetLimit);
    else set_reg(REG_HIT_LIMIT, $urandom_range(4, 1));
    r = $urandom_range(3);
    if (r == 0) set_reg(REG_START_ADDRESS, 32'hFFFF_FFFF - $urandom_range(20));
    else if (r == 1) set_reg(REG_START_ADDRESS, 0);
    else set_reg(REG_START_ADDRESS, $urandom);
    load_pattern(act_len);
    runs = $urandom_range(5, 2);
    for (int unsigned k = 0; k < runs; k++)
      scan_run($urandom_range(40, 1), $urandom_range(1), (phase % 3 == 0) ? 3 : 0,
               (phase % 5 == 1) && (k == 0));
  endtask

  initial begin
    int start_items;
    rst_ni       = 1'b0;
    cfg_we       = 1'b0;
    cfg_idx      = '0;
    cfg_data     = '0;
    in_ch.valid  = 1'b0;
    in_ch.item   = '0;
    idle_pct     = 0;
    stall_pct    = 0;
    load_count   = 0;
    scan_count   = 0;
    phase        = 0;
    act_len      = 1;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    directed_part();
    start_items = load_count + scan_count;
    while (load_count + scan_count - start_items < RandomItems) begin
      case (phase % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 73; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 73; end
        default: begin idle_pct = 34; stall_pct = 34; end
      endcase
      if (phase == 2) long_pattern_phase();
      else random_phase();
      phase++;
    end
    settle(1'b1);

    $display("Ran %0d phases: %0d pattern loads and %0d scan bytes, %0d cycles.",
             phase, load_count, scan_count, cycle_count);
    $display("Compared %0d hits and %0d end-of-scan summaries, %0d of them truncated.",
             chk_hits, chk_summaries, chk_truncations);
    if (chk_failures == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
